/* hw/rtl/pce_pkg.sv */
`timescale 1ns / 1ps
// pce_pkg: shared types and constants for the pin change edge event block
// no dependencies; imported by every module of the block

package pce_pkg;

  // port geometry
  localparam int PORT_BITS = 16;
  localparam int PIN_NUM_W = 8;
  localparam int PORT_IDX_W = 4;
  localparam int BIT_IDX_W = 4;

  // config bus geometry
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W = 2;

  // register indexes, byte address is 4 * index
  localparam logic [REG_IDX_W-1:0] REG_CHANGE_EN  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RISING_EN  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FALLING_EN = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_PORT_IDX   = 2'd3;

  typedef logic [PORT_BITS-1:0] word_t;

  // configuration seen by the datapath
  typedef struct packed {
    word_t                 change_enable;
    word_t                 rising_enable;
    word_t                 falling_enable;
    logic [PORT_IDX_W-1:0] port_index;
  } cfg_t;

  // one sample's worth of pending events for the emitter
  typedef struct packed {
    word_t                mask;
    word_t                level;
    logic [PIN_NUM_W-1:0] base;
  } evset_t;

endpackage

/* hw/rtl/pce_regs.sv */
`timescale 1ns / 1ps
// pce_regs: APB-style configuration registers for the pin change block
// depends on pce_pkg

module pce_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pce_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pce_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pce_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output pce_pkg::cfg_t                 cfg
);
  import pce_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_CHANGE_EN:  cfg_nxt.change_enable  = pwdata[PORT_BITS-1:0];
        REG_RISING_EN:  cfg_nxt.rising_enable  = pwdata[PORT_BITS-1:0];
        REG_FALLING_EN: cfg_nxt.falling_enable = pwdata[PORT_BITS-1:0];
        REG_PORT_IDX:   cfg_nxt.port_index     = pwdata[PORT_IDX_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_CHANGE_EN:  prdata = CFG_DATA_W'(cfg_r.change_enable);
      REG_RISING_EN:  prdata = CFG_DATA_W'(cfg_r.rising_enable);
      REG_FALLING_EN: prdata = CFG_DATA_W'(cfg_r.falling_enable);
      REG_PORT_IDX:   prdata = CFG_DATA_W'(cfg_r.port_index);
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/pce_detect.sv */
`timescale 1ns / 1ps
// pce_detect: masks each sample, compares with the stored masked word and
// builds the set of reportable edges; depends on pce_pkg

module pce_detect #(
  parameter int PINS_PER_PORT = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  pce_pkg::word_t  port_level,
  input  pce_pkg::cfg_t   cfg,
  output pce_pkg::evset_t evset
);
  import pce_pkg::*;

  localparam word_t PIN_MASK = (PINS_PER_PORT >= PORT_BITS) ? {PORT_BITS{1'b1}} :
                               PORT_BITS'((32'd1 << PINS_PER_PORT) - 32'd1);
  localparam int PROD_W = 12;

  word_t             prev_r;
  word_t             prev_nxt;
  word_t             current;
  word_t             changes;
  logic [PROD_W-1:0] base_prod;

  // masked sample and changed pins
  assign current = port_level & cfg.change_enable & PIN_MASK;
  assign changes = current ^ prev_r;

  // keep only edges whose direction is enabled
  assign evset.mask  = changes & ((current & cfg.rising_enable) |
                                  (~current & cfg.falling_enable));
  assign evset.level = current;

  // pin number offset of this port, wraps at 8 bits
  assign base_prod  = PROD_W'(cfg.port_index) * PROD_W'(PINS_PER_PORT);
  assign evset.base = base_prod[PIN_NUM_W-1:0];

  // stored masked levels
  assign prev_nxt = accept ? current : prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

/* hw/rtl/pce_emit.sv */
`timescale 1ns / 1ps
// pce_emit: holds the pending edge set and sends one event per cycle while
// out_stall is low, lowest pin first, through the output register; depends on pce_pkg

module pce_emit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  pce_pkg::evset_t                 evset,
  output logic                            busy,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pce_pkg::PIN_NUM_W-1:0]   out_pin_number,
  output logic                            out_new_level,
  output logic                            out_last_event
);
  import pce_pkg::*;

  word_t                mask_r;
  word_t                mask_nxt;
  word_t                level_r;
  logic [PIN_NUM_W-1:0] base_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [PIN_NUM_W-1:0] out_pin_r;
  logic                 out_level_r;
  logic                 out_last_r;
  word_t                low_bit;
  word_t                mask_rest;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic                 advance;
  logic                 pending;

  // isolate lowest pending pin
  assign low_bit   = mask_r & (~mask_r + word_t'(1));
  assign mask_rest = mask_r & ~low_bit;
  assign pending   = |mask_r;

  always_comb begin
    bit_idx = '0;
    for (int i = 0; i < PORT_BITS; i++) begin
      if (low_bit[i]) begin
        bit_idx = BIT_IDX_W'(i);
      end
    end
  end

  // output register moves when empty or taken
  assign advance = !out_valid_r || !out_stall;

  // a new sample may enter once the set's last event moves to the output register
  assign busy = advance ? (|mask_rest) : pending;

  always_comb begin
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      mask_nxt      = mask_rest;
      out_valid_nxt = pending;
    end
    if (accept) begin
      mask_nxt = evset.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      level_r <= evset.level;
      base_r  <= evset.base;
    end
    if (advance && pending) begin
      out_pin_r   <= base_r + PIN_NUM_W'(bit_idx);
      out_level_r <= |(low_bit & level_r);
      out_last_r  <= ~|mask_rest;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pin_number = out_pin_r;
  assign out_new_level  = out_level_r;
  assign out_last_event = out_last_r;

endmodule

/* hw/rtl/pin_change_edge_events.sv */
`timescale 1ns / 1ps
// pin_change_edge_events: top level of the pin change edge event block
// depends on pce_pkg, pce_regs, pce_detect, pce_emit
//
//   channel  direction  handshake           payload
//   in_      request in in_valid/in_stall   in_port_level[15:0]
//   out_     event out  out_valid/out_stall out_pin_number[7:0], out_new_level,
//                                           out_last_event
//   config   APB        psel/penable/pready paddr[3:0], pwdata/prdata[31:0]
//
// a sample is taken every cycle while in_stall is low; its events pass from the
// pending mask register to the output register, one per cycle while out_stall is low
// a sample with more than one reported edge holds in_stall while the emitter
// drains all but its last, longer if out_stall holds the output register
// synchronous active-low reset clears the stored levels, config, pending edges and out_valid

module pin_change_edge_events #(
  parameter int PINS_PER_PORT = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pce_pkg::PORT_BITS-1:0]    in_port_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pce_pkg::PIN_NUM_W-1:0]    out_pin_number,
  output logic                             out_new_level,
  output logic                             out_last_event,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pce_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pce_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pce_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import pce_pkg::*;

  cfg_t   cfg;
  evset_t evset;
  logic   busy;
  logic   in_accept;

  // request handshake
  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;

  pce_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pce_detect #(
    .PINS_PER_PORT (PINS_PER_PORT)
  ) u_detect (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .port_level (in_port_level),
    .cfg        (cfg),
    .evset      (evset)
  );

  pce_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .evset          (evset),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pin_number (out_pin_number),
    .out_new_level  (out_new_level),
    .out_last_event (out_last_event)
  );

endmodule
